>>> src/assert_macros.svh
// Assertion macros used by the word table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check of prop on every rising edge outside reset.
`define WWTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Concurrent check that cond never holds outside reset.
`define WWTS_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) !(cond)) else $error(msg);

`else

`define WWTS_ASSERT(lbl, clk, rst, prop, msg)
`define WWTS_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> src/wwts_pkg.sv
// Shared types and constants of the wildcard word table search unit.
`timescale 1ns / 1ps

package wwts_pkg;

  localparam int unsigned LEN_W          = 5;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned WORD_BYTES     = WORD_W / 8;
  localparam int unsigned COUNT_W        = 6;
  localparam int unsigned TABLE_SLOTS_DEF = 32;
  localparam logic [LEN_W-1:0] MAX_WORD_BYTES = LEN_W'(16);
  localparam logic [7:0] WILDCARD = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_WORD   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EXISTS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LEN_W-1:0]  word_length;
    logic [WORD_W-1:0] bytes_first_eight;
    logic [WORD_W-1:0] bytes_last_eight;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [COUNT_W-1:0] match_count;
    logic [LEN_W-1:0]   out_length;
    logic [WORD_W-1:0]  out_first_eight;
    logic [WORD_W-1:0]  out_last_eight;
    logic               last;
  } res_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;         // capture input item, clear scan state
    logic       rd_en;        // read slot at scan index, advance index
    logic       rewind;       // restart scan index for the emit pass
    logic       acc;          // count hits of returning reads
    logic       do_add;       // write word into next unused slot
    logic       do_del;       // clear live mark of found slot
    logic       emit_status;
    logic       emit_count;
    logic       emit_word;
    logic [1:0] status;       // status code for emit_status
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_e  op;
    logic bad_len;
    logic found;
    logic full;
    logic cnt_zero;
    logic more_slots;
    logic scan_done;
    logic hit;
    logic last_word;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> src/wwts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wwts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/wwts_ctrl.sv
// Command sequencer of the word table: scan pass, status, emit pass.
`timescale 1ns / 1ps

module wwts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_stall_o,
  input  wwts_pkg::ctl_sts_t  sts_i,
  output wwts_pkg::ctl_cmd_t  ctl_o
);
  import wwts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_EMIT_RD,
    S_EMIT_CHK
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_vld_i && !in_stall_q) begin
          ctl_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.acc = 1'b1;
        if (sts_i.more_slots) begin
          ctl_o.rd_en = 1'b1;
        end else if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        unique case (sts_i.op)
          OP_NOP: begin
            state_d = S_IDLE;
          end
          OP_ADD: begin
            if (sts_i.out_free) begin
              ctl_o.emit_status = 1'b1;
              priority if (sts_i.bad_len) begin
                ctl_o.status = ST_BAD_LEN;
              end else if (sts_i.found) begin
                ctl_o.status = ST_EXISTS;
              end else if (sts_i.full) begin
                ctl_o.status = ST_FULL;
              end else begin
                ctl_o.status = ST_DONE;
                ctl_o.do_add = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          OP_DEL: begin
            if (sts_i.out_free) begin
              ctl_o.emit_status = 1'b1;
              priority if (sts_i.bad_len) begin
                ctl_o.status = ST_BAD_LEN;
              end else if (sts_i.found) begin
                ctl_o.status = ST_DONE;
                ctl_o.do_del = 1'b1;
              end else begin
                ctl_o.status = ST_EXISTS;
              end
              state_d = S_IDLE;
            end
          end
          OP_QUERY: begin
            if (sts_i.out_free) begin
              ctl_o.emit_count = 1'b1;
              if (sts_i.cnt_zero) begin
                state_d = S_IDLE;
              end else begin
                ctl_o.rewind = 1'b1;
                state_d      = S_EMIT_RD;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT_RD: begin
        if (sts_i.more_slots) begin
          ctl_o.rd_en = 1'b1;
          state_d     = S_EMIT_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_CHK: begin
        if (!sts_i.hit) begin
          state_d = S_EMIT_RD;
        end else if (sts_i.out_free) begin
          ctl_o.emit_word = 1'b1;
          state_d = sts_i.last_word ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_stall_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = in_stall_q;

endmodule

>>> src/wwts_dpath.sv
// Datapath of the word table: slot RAM, live bits, compare, counters, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wwts_dpath #(
  parameter int unsigned TABLE_SLOTS = wwts_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wwts_pkg::cmd_item_t in_item_i,
  input  wwts_pkg::ctl_cmd_t  ctl_i,
  output wwts_pkg::ctl_sts_t  sts_o,
  input  logic                out_stall_i,
  output logic                out_vld_o,
  output wwts_pkg::res_item_t out_item_o
);
  import wwts_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W = LEN_W + 2 * WORD_W;
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(TABLE_SLOTS);

  // Command register; bytes past the length are zeroed on capture.
  op_e               op_q;
  logic [LEN_W-1:0]  len_q;
  logic [WORD_W-1:0] lo_q, hi_q, lo_in, hi_in;

  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      lo_in[8*b +: 8] = (LEN_W'(b) < in_item_i.word_length) ?
                        in_item_i.bytes_first_eight[8*b +: 8] : 8'h00;
      hi_in[8*b +: 8] = (LEN_W'(b + WORD_BYTES) < in_item_i.word_length) ?
                        in_item_i.bytes_last_eight[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= op_e'(in_item_i.opcode);
      len_q <= in_item_i.word_length;
      lo_q  <= lo_in;
      hi_q  <= hi_in;
    end
  end

  logic bad_len;
  assign bad_len = (len_q == '0) || (len_q > MAX_WORD_BYTES);

  // Scan and table state.
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       seen_q, seen_d, seen_nxt;
  logic [IDX_W-1:0]       rd_idx_q, found_idx_q, found_idx_d;
  logic                   rd_vld_q, rd_live_q, found_q, found_d;
  logic [TABLE_SLOTS-1:0] live_q, live_d;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [ENTRY_W-1:0]     rd_data;

  assign rd_addr = idx_q[IDX_W-1:0];
  assign wr_addr = used_q[IDX_W-1:0];

  wwts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctl_i.do_add),
    .wr_addr_i (wr_addr),
    .wr_data_i ({len_q, hi_q, lo_q}),
    .rd_en_i   (ctl_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Compare of the slot read back against the command.
  logic [WORD_W-1:0]       r_lo, r_hi;
  logic [LEN_W-1:0]        r_len;
  logic [2*WORD_BYTES-1:0] byte_ok;
  logic                    len_eq, pat_hit, exact_hit, hit;

  assign r_lo  = rd_data[WORD_W-1:0];
  assign r_hi  = rd_data[2*WORD_W-1:WORD_W];
  assign r_len = rd_data[ENTRY_W-1:2*WORD_W];

  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      byte_ok[b] = (lo_q[8*b +: 8] == WILDCARD) || (lo_q[8*b +: 8] == r_lo[8*b +: 8]);
      byte_ok[b + WORD_BYTES] = (hi_q[8*b +: 8] == WILDCARD) ||
                                (hi_q[8*b +: 8] == r_hi[8*b +: 8]);
    end
  end

  assign len_eq    = rd_live_q && (r_len == len_q);
  assign pat_hit   = len_eq && (&byte_ok);
  assign exact_hit = len_eq && (r_lo == lo_q) && (r_hi == hi_q);
  assign hit       = (op_q == OP_QUERY) ? pat_hit : exact_hit;
  assign seen_nxt  = seen_q + CNT_W'(1);

  always_comb begin
    idx_d       = idx_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    live_d      = live_q;
    if (ctl_i.load || ctl_i.rewind) begin
      idx_d  = '0;
      seen_d = '0;
    end else if (ctl_i.rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (ctl_i.load) begin
      cnt_d   = '0;
      found_d = 1'b0;
    end else if (ctl_i.acc && rd_vld_q && hit) begin
      cnt_d       = cnt_q + CNT_W'(1);
      found_d     = 1'b1;
      found_idx_d = rd_idx_q;
    end
    if (ctl_i.emit_word) begin
      seen_d = seen_nxt;
    end
    if (ctl_i.do_add) begin
      live_d[wr_addr] = 1'b1;
      used_d          = used_q + CNT_W'(1);
    end
    if (ctl_i.do_del) begin
      live_d[found_idx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      seen_q      <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      live_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_live_q   <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      idx_q       <= idx_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      found_q     <= found_d;
      found_idx_q <= found_idx_d;
      live_q      <= live_d;
      rd_vld_q    <= ctl_i.rd_en;
      if (ctl_i.rd_en) begin
        rd_live_q <= live_q[rd_addr];
        rd_idx_q  <= rd_addr;
      end
    end
  end

  // Result register: a new item loads as the previous one leaves.
  logic      out_vld_q, out_free;
  res_item_t out_q;

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.emit_status || ctl_i.emit_count || ctl_i.emit_word) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_status) begin
      out_q <= '{kind: KIND_STATUS, status: ctl_i.status, match_count: '0,
                 out_length: '0, out_first_eight: '0, out_last_eight: '0, last: 1'b1};
    end else if (ctl_i.emit_count) begin
      out_q <= '{kind: KIND_COUNT, status: ST_DONE, match_count: COUNT_W'(cnt_q),
                 out_length: '0, out_first_eight: '0, out_last_eight: '0,
                 last: (cnt_q == '0)};
    end else if (ctl_i.emit_word) begin
      out_q <= '{kind: KIND_WORD, status: ST_DONE, match_count: '0,
                 out_length: r_len, out_first_eight: r_lo, out_last_eight: r_hi,
                 last: (seen_nxt == cnt_q)};
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_item_o = out_q;

  assign sts_o = '{op: op_q, bad_len: bad_len, found: found_q, full: (used_q == SLOTS_FULL),
                   cnt_zero: (cnt_q == '0), more_slots: (idx_q < used_q),
                   scan_done: (!rd_vld_q && (idx_q == used_q)), hit: hit,
                   last_word: (seen_nxt == cnt_q), out_free: out_free};

  `WWTS_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= SLOTS_FULL, "slot count past table size")
  `WWTS_ASSERT(a_add_not_full, clk_i, rst_ni, ctl_i.do_add |-> (used_q != SLOTS_FULL), "add into full table")
  `WWTS_ASSERT(a_rd_in_range, clk_i, rst_ni, ctl_i.rd_en |-> (idx_q < used_q), "read of unused slot")
  `WWTS_ASSERT(a_word_is_hit, clk_i, rst_ni, ctl_i.emit_word |-> hit, "word item without match")
  `WWTS_NEVER(a_no_overwrite, clk_i, rst_ni, (ctl_i.emit_status || ctl_i.emit_count || ctl_i.emit_word) && out_vld_q && out_stall_i, "result overwritten while held")

endmodule

>>> src/wildcard_word_table_search_unit.sv
// Top level of the wildcard word table search unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  command | in        | in_vld_i / in_stall_o | in_item_i  (opcode, length, bytes)
//  result  | out       | out_vld_o / out_stall_i | out_item_o (kind, status, count, word)
//
// One command at a time. The slot RAM has one read port with registered read data:
// a scan pass streams one slot per cycle through it. A query then runs an emit pass
// that reads each slot in turn, then compares it and loads the result register on a
// hit; the pass ends at the last matching slot and is skipped on a zero count. The
// sequencer waits while the result side stalls before it loads the result register.
// Reset clears live bits and the used-slot count; slot contents need no clearing.
// A finished result waits in the output register while the next command is taken.
`timescale 1ns / 1ps

module wildcard_word_table_search_unit #(
  parameter int unsigned TABLE_SLOTS = wwts_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_stall_o,
  input  wwts_pkg::cmd_item_t in_item_i,
  output logic                out_vld_o,
  input  logic                out_stall_i,
  output wwts_pkg::res_item_t out_item_o
);
  import wwts_pkg::*;

  ctl_cmd_t ctl;   // sequencer commands to the datapath
  ctl_sts_t sts;   // compare results, counters and result-register state

  // Sequencer: scan, decide, emit.
  wwts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_vld_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Slot storage, compare logic and result register.
  wwts_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_vld_o   (out_vld_o),
    .out_item_o  (out_item_o)
  );

endmodule
